@@ rtl/rae_pkg.sv @@
package rae_pkg;

	// Data path and register file geometry.
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 4;
	localparam int NUM_REGS = 16;
	localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CNT_W    = $clog2(DATA_W);
	localparam int OP_W     = 3;

	// Operation codes carried by an item.
	typedef enum logic [OP_W-1:0] {
		OP_LDI = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_MOD = 3'd5,
		OP_RD  = 3'd6
	} op_t;

	// Write port of the register file.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} rf_wr_t;

	// An index addresses a real register only when it lies below the register count.
	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		return (32'(idx) < NUM_REGS);
	endfunction

endpackage

@@ rtl/rae_regfile.sv @@
module rae_regfile import rae_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  raddr_a,
	input  logic [IDX_W-1:0]  raddr_b,
	input  rf_wr_t            wr,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0]   mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic                wr_ok;

	assign wr_ok = wr.en && idx_ok(wr.idx);

	// Valid bits stand in for clearing the array: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[REG_AW'(wr.idx)] <= 1'b1;
		end
	end

	// Array write and the two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[REG_AW'(wr.idx)] <= wr.data;
		end
		rdata_a <= (idx_ok(raddr_a) && valid_q[REG_AW'(raddr_a)]) ?
			mem_q[REG_AW'(raddr_a)] : '0;
		rdata_b <= (idx_ok(raddr_b) && valid_q[REG_AW'(raddr_b)]) ?
			mem_q[REG_AW'(raddr_b)] : '0;
	end

endmodule

@@ rtl/register_alu_execute.sv @@
// Execute unit of a small register machine with sixteen 32-bit registers.
// Command channel: an item (op, dest_index, src_index, immediate) is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// item's result has been produced.
// Result channel: done is high for exactly one cycle with reg_value (register A
// after the operation) and zero_divisor. The receiver cannot stall; the result
// is gone after that cycle, and every item gives exactly one result.
// Load, add, sub and read finish in the decode state; mul goes on through
// the iteration and fixup states; div and mod through negate A, negate B,
// iteration and fixup, or finish in decode on a zero divisor. A new item
// may be given in the cycle where done is high. All arithmetic runs through
// one 34-bit adder: mul is shift-and-add and div/mod are restoring division,
// one bit per cycle; the adder also forms each operand magnitude and the final sign fix.
// Reset clears every register to zero and returns the block to idle.
module register_alu_execute import rae_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [OP_W-1:0]          op,
	input  logic [IDX_W-1:0]         dest_index,
	input  logic [IDX_W-1:0]         src_index,
	input  logic signed [DATA_W-1:0] immediate,
	output logic                     busy,
	output logic                     done,
	output logic signed [DATA_W-1:0] reg_value,
	output logic                     zero_divisor
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_NEG_A,
		S_NEG_B,
		S_ITER,
		S_FIXUP
	} state_t;

	localparam int ADD_W = DATA_W + 2;

	state_t              state_q;
	op_t                 op_q;
	logic [IDX_W-1:0]    dest_q;
	logic [DATA_W-1:0]   imm_q;
	logic [DATA_W-1:0]   opa_q;
	logic [DATA_W-1:0]   opb_q;
	logic [DATA_W-1:0]   acc_q;
	logic                neg_a_q;
	logic                neg_b_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                zdiv_q;
	logic [DATA_W-1:0]   value_q;

	logic [DATA_W-1:0]   rdata_a;
	logic [DATA_W-1:0]   rdata_b;
	rf_wr_t              wr;

	logic [ADD_W-1:0]    add_a;
	logic [ADD_W-1:0]    add_b;
	logic                add_sub;
	logic [ADD_W-1:0]    add_sum;

	logic                fin;
	logic                fin_wr;
	logic                fin_flag;
	logic [DATA_W-1:0]   fin_val;

	rae_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.raddr_a (dest_index),
		.raddr_b (src_index),
		.wr      (wr),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Operand selection for the shared adder.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_DECODE: begin
				add_a   = {2'b00, rdata_a};
				add_b   = {2'b00, rdata_b};
				add_sub = (op_q == OP_SUB);
			end
			S_NEG_A: begin
				add_b   = {2'b00, opa_q};
				add_sub = 1'b1;
			end
			S_NEG_B: begin
				add_b   = {2'b00, opb_q};
				add_sub = 1'b1;
			end
			S_ITER: begin
				if (op_q == OP_MUL) begin
					add_a = {2'b00, acc_q};
					add_b = {2'b00, opa_q};
				end else begin
					add_a   = {1'b0, acc_q, opa_q[DATA_W-1]};
					add_b   = {2'b00, opb_q};
					add_sub = 1'b1;
				end
			end
			S_FIXUP: begin
				add_b   = {2'b00, (op_q == OP_MOD) ? acc_q : opa_q};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	// The shared adder: add, or subtract by inverting and carrying in.
	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

	// Completion of an item: its value, whether it is written back, and the flag.
	always_comb begin
		fin      = 1'b0;
		fin_wr   = 1'b0;
		fin_flag = 1'b0;
		fin_val  = rdata_a;
		unique case (state_q)
			S_DECODE: begin
				case (op_q) inside
					OP_LDI: begin
						fin     = 1'b1;
						fin_wr  = 1'b1;
						fin_val = imm_q;
					end
					OP_ADD, OP_SUB: begin
						fin     = 1'b1;
						fin_wr  = 1'b1;
						fin_val = add_sum[DATA_W-1:0];
					end
					OP_MUL: begin
						fin = 1'b0;
					end
					OP_DIV, OP_MOD: begin
						fin      = (rdata_b == '0);
						fin_flag = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_FIXUP: begin
				fin    = 1'b1;
				fin_wr = 1'b1;
				case (op_q)
					OP_DIV:  fin_val = (neg_a_q ^ neg_b_q) ? add_sum[DATA_W-1:0] : opa_q;
					OP_MOD:  fin_val = neg_a_q ? add_sum[DATA_W-1:0] : acc_q;
					default: fin_val = acc_q;
				endcase
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Write-back into the register file.
	always_comb begin
		wr.en   = fin && fin_wr;
		wr.idx  = dest_q;
		wr.data = fin_val;
	end

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RD;
			dest_q  <= '0;
			imm_q   <= '0;
			opa_q   <= '0;
			opb_q   <= '0;
			acc_q   <= '0;
			neg_a_q <= 1'b0;
			neg_b_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			zdiv_q  <= 1'b0;
			value_q <= '0;
		end else begin
			done_q <= fin;
			zdiv_q <= fin && fin_flag;
			if (fin) begin
				value_q <= idx_ok(dest_q) ? fin_val : '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op_t'(op);
						dest_q  <= dest_index;
						imm_q   <= immediate;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					opa_q   <= rdata_a;
					opb_q   <= rdata_b;
					neg_a_q <= rdata_a[DATA_W-1];
					neg_b_q <= rdata_b[DATA_W-1];
					acc_q   <= '0;
					cnt_q   <= '1;
					if (fin) begin
						state_q <= S_IDLE;
					end else if (op_q == OP_MUL) begin
						state_q <= S_ITER;
					end else begin
						state_q <= S_NEG_A;
					end
				end
				S_NEG_A: begin
					if (neg_a_q) begin
						opa_q <= add_sum[DATA_W-1:0];
					end
					state_q <= S_NEG_B;
				end
				S_NEG_B: begin
					if (neg_b_q) begin
						opb_q <= add_sum[DATA_W-1:0];
					end
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (op_q == OP_MUL) begin
						// Shift-and-add: one multiplier bit per cycle.
						if (opb_q[0]) begin
							acc_q <= add_sum[DATA_W-1:0];
						end
						opa_q <= {opa_q[DATA_W-2:0], 1'b0};
						opb_q <= {1'b0, opb_q[DATA_W-1:1]};
					end else begin
						// Restoring division: keep the trial difference when it is not negative.
						if (!add_sum[ADD_W-1]) begin
							acc_q <= add_sum[DATA_W-1:0];
						end else begin
							acc_q <= {acc_q[DATA_W-2:0], opa_q[DATA_W-1]};
						end
						opa_q <= {opa_q[DATA_W-2:0], ~add_sum[ADD_W-1]};
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_FIXUP;
					end
				end
				S_FIXUP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign zero_divisor = zdiv_q;
	assign reg_value    = value_q;

endmodule

@@ rtl/rae_checker.sv @@
module rae_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic zero_divisor
);

	// An accepted item makes the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but unit not busy");

	// A result strobe always ends a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result without a preceding busy period");

	// The result strobe is a one-cycle pulse.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The zero-divisor flag is only shown with a result.
	a_flag_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		zero_divisor |-> done)
		else $error("zero divisor flag outside a result");

	// Busy rises only because an item was taken.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("unit became busy without an item");

endmodule

bind register_alu_execute rae_checker u_rae_checker (.*);
